/* sv/ehsi_pkg.sv */
package ehsi_pkg;

  // Field and state widths.
  localparam int BYTE_W  = 8;
  localparam int HASH_W  = 28;
  localparam int SLOTS_W = 31;
  localparam int TDATA_W = 32;
  localparam int CNT_W   = 5;

  // Last step of the remainder loop: one step for each bit of the hash.
  localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(HASH_W - 1);

  // Sequencer state codes.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  typedef logic [HASH_W-1:0]  hash_t;
  typedef logic [SLOTS_W-1:0] slots_t;

  // Status returned by the remainder unit to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* sv/ehsi_fold.sv */
module ehsi_fold
  import ehsi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              clear,
  input  logic [BYTE_W-1:0] key_byte,
  output hash_t             hash_folded,
  output hash_t             hash
);

  logic [HASH_W+3:0] sum;
  logic [3:0]        top;

  // Shift in the byte; the top nibble is folded in at bit 4 and dropped.
  always_comb begin
    sum         = {hash, 4'b0000} + {{(HASH_W-4){1'b0}}, key_byte};
    top         = sum[HASH_W+3:HASH_W];
    hash_folded = sum[HASH_W-1:0] ^ {{(HASH_W-8){1'b0}}, top, 4'b0000};
  end

  // Running hash: cleared after the last byte of each key.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= '0;
    end else if (step) begin
      if (clear) begin
        hash <= '0;
      end else begin
        hash <= hash_folded;
      end
    end
  end

endmodule

/* sv/ehsi_div.sv */
module ehsi_div
  import ehsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  hash_t       dividend,
  input  slots_t      divisor,
  output div_status_t status,
  output hash_t       remainder
);

  hash_t            quo;
  hash_t            rem;
  slots_t           dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  hash_t            trial;
  slots_t           diff;
  logic             fits;

  // One restoring step: bring down the next bit and subtract if it fits.
  always_comb begin
    trial = {rem[HASH_W-2:0], quo[HASH_W-1]};
    fits  = {{(SLOTS_W-HASH_W){1'b0}}, trial} >= dvs;
    diff  = {{(SLOTS_W-HASH_W){1'b0}}, trial} - dvs;
  end

  // Control of the subtract/compare unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend bits, partial remainder and latched divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[HASH_W-2:0], 1'b0};
      rem <= fits ? diff[HASH_W-1:0] : trial;
    end
  end

  assign status    = '{busy: busy, done: done};
  assign remainder = rem;

endmodule

/* sv/elf_hash_slot_index.sv */
// Channel | Direction | Contents
// s_axis  | in        | tdata[7:0] key_byte; tlast last_byte
// m_axis  | out       | tdata[30:0] slot_index; tuser error
// cfg     | in        | wr_en/wr_data: num_slots (31 bits, reset 1)
//
// A byte that is not the last of its key is folded into the hash as it is accepted.
// The last byte holds off the next byte until its result is written: the block accepts it,
// the restoring remainder unit runs at one hash bit per cycle, hands the remainder
// back to the sequencer, and then the result register is written.
// With a zero slot count no division runs; the block goes straight to the write.
// Reset is synchronous and active high; it clears the hash and sets
// num_slots to 1. A result waiting in the output register only stalls
// the block when the next result is ready to be written.
module elf_hash_slot_index
  import ehsi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] key_byte
  input  logic               s_axis_tlast,   // last_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // [30:0] slot_index, [31] zero
  output logic               m_axis_tuser,   // error
  input  logic               cfg_wr_en,
  input  slots_t             cfg_wr_data
);

  logic [1:0]  state;
  slots_t      num_slots;
  logic        err;
  logic        s_accept;
  logic        out_free;
  hash_t       hash_folded;
  hash_t       hash;
  hash_t       remainder;
  div_status_t div_stat;
  logic        div_start;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign div_start     = s_accept && s_axis_tlast && (num_slots != '0);

  // Slot count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_slots <= SLOTS_W'(1);
    end else if (cfg_wr_en) begin
      num_slots <= cfg_wr_data;
    end
  end

  ehsi_fold u_fold (
    .clk         (clk),
    .rst         (rst),
    .step        (s_accept),
    .clear       (s_axis_tlast),
    .key_byte    (s_axis_tdata),
    .hash_folded (hash_folded),
    .hash        (hash)
  );

  ehsi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (hash_folded),
    .divisor   (num_slots),
    .status    (div_stat),
    .remainder (remainder)
  );

  // Sequencer: fold bytes, run the remainder unit, then write the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      err   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_accept && s_axis_tlast) begin
            err   <= (num_slots == '0);
            state <= (num_slots == '0) ? ST_WRITE : ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register for the result transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_WRITE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE && out_free) begin
      m_axis_tdata <= err ? '0 : {{(TDATA_W-HASH_W){1'b0}}, remainder};
      m_axis_tuser <= err;
    end
  end

`ifndef SYNTHESIS
  // The hash starts afresh after the last byte of a key.
  assert property (@(posedge clk) disable iff (rst)
    s_accept && s_axis_tlast |=> hash == '0)
    else $error("hash not cleared after last byte");

  // The remainder unit works only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> state == ST_DIV)
    else $error("remainder unit busy outside division");

  // The remainder unit finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("remainder unit finished outside division");

  // An error result carries a zero index.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("error result with nonzero index");
`endif

endmodule

/* tb/elf_hash_slot_index_tb.sv */
module elf_hash_slot_index_tb
  import ehsi_pkg::*;
();

  // Hashing constants of the ELF/PJW scheme.
  localparam logic [31:0] TOP_NIBBLE  = 32'hf000_0000;
  localparam int          FOLD_SHIFT  = 24;
  localparam int          STEP_SHIFT  = 4;
  localparam slots_t      SLOTS_RESET = SLOTS_W'(1);
  localparam slots_t      SLOTS_MAX   = {SLOTS_W{1'b1}};

  // Quiet cycles before a slot-count write and at the end of the run.
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_BYTES   = 60;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic [1:0] {JOB_BYTE, JOB_SLOTS, JOB_SETTLE} job_kind_t;
  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_BLOCKY} sink_mode_t;

  typedef struct {
    job_kind_t          kind;
    logic [BYTE_W-1:0]  key_byte;
    logic               last;
    slots_t             slots;
  } job_t;

  typedef struct {
    slots_t slot;
    logic   err;
  } slot_check_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [BYTE_W-1:0]  s_axis_tdata = '0;   // [7:0] key_byte
  logic               s_axis_tlast = 1'b0; // last_byte
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;        // [30:0] slot_index, [31] zero
  logic               m_axis_tuser;        // error
  logic               cfg_wr_en = 1'b0;
  slots_t             cfg_wr_data = '0;

  job_t        pending_jobs[$];
  slot_check_t slot_checks[$];

  // Predictor state and run statistics.
  hash_t  model_hash;
  slots_t model_slots;
  logic   key_taken = 1'b0;
  int     fail_count = 0;
  int     keys_done = 0;
  int     bytes_taken = 0;
  int     error_keys = 0;
  int     slot_writes = 0;
  int     burst_left = 1;
  int     gap_left = 0;
  int     settle_left = SETTLE_CYCLES;
  int     sink_left = 0;
  int     stall_left = 0;
  sink_mode_t sink_mode = SINK_OPEN;

  elf_hash_slot_index uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One ELF/PJW step: shift in the byte, then fold the top nibble down to bit 4.
  function automatic hash_t elf_fold(hash_t h, logic [BYTE_W-1:0] b);
    logic [31:0] acc;
    logic [31:0] top;
    acc = (32'(h) << STEP_SHIFT) + 32'(b);
    top = acc & TOP_NIBBLE;
    if (top != 32'd0) begin
      acc = acc ^ (top >> FOLD_SHIFT) ^ top;
    end
    return acc[HASH_W-1:0];
  endfunction

  task automatic queue_byte(logic [BYTE_W-1:0] b, logic last);
    job_t job;
    job = '{kind: JOB_BYTE, key_byte: b, last: last, slots: '0};
    pending_jobs.push_back(job);
  endtask

  task automatic queue_slots(slots_t value);
    job_t job;
    job = '{kind: JOB_SLOTS, key_byte: '0, last: 1'b0, slots: value};
    pending_jobs.push_back(job);
  endtask

  task automatic queue_settle();
    job_t job;
    job = '{kind: JOB_SETTLE, key_byte: '0, last: 1'b0, slots: '0};
    pending_jobs.push_back(job);
  endtask

  // A key of random bytes; returns its length.
  task automatic queue_random_key(output int len);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      queue_byte(BYTE_W'($urandom()), i == len - 1);
    end
  endtask

  task automatic report_failure(string what, logic [TDATA_W-1:0] exp_data, logic exp_err,
                                logic [TDATA_W-1:0] act_data, logic act_err);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected tdata %h tuser %b, got tdata %h tuser %b",
               $realtime, what, exp_data, exp_err, act_data, act_err);
    end
  endtask

  // Key sender: bursts of bytes with gaps, and slot-count writes once quiet.
  always @(negedge clk) begin : feed_keys
    job_t job;
    logic nxt_valid;
    logic nxt_wr;
    nxt_valid = s_axis_tvalid && !key_taken;
    nxt_wr = 1'b0;
    if (!rst && !nxt_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_jobs.size() != 0) begin
        job = pending_jobs[0];
        if (job.kind == JOB_BYTE) begin
          void'(pending_jobs.pop_front());
          nxt_valid = 1'b1;
          s_axis_tdata <= job.key_byte;
          s_axis_tlast <= job.last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else if (slot_checks.size() != 0) begin
          settle_left = SETTLE_CYCLES;
        end else if (settle_left > 0) begin
          settle_left--;
        end else begin
          void'(pending_jobs.pop_front());
          settle_left = SETTLE_CYCLES;
          if (job.kind == JOB_SLOTS) begin
            nxt_wr = 1'b1;
            cfg_wr_data <= job.slots;
          end
        end
      end
    end
    s_axis_tvalid <= nxt_valid;
    cfg_wr_en <= nxt_wr;
  end

  // Result receiver: open stretches, coin-toss readiness and long stalls.
  always @(negedge clk) begin : sink_pattern
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 2));
      sink_left = $urandom_range(20, 300);
    end else begin
      sink_left--;
    end
    case (sink_mode)
      SINK_OPEN: begin
        m_axis_tready <= 1'b1;
      end
      SINK_COIN: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else begin
          stall_left = $urandom_range(5, 40);
          m_axis_tready <= 1'b1;
        end
      end
    endcase
  end

  // Monitor: predicts on each accepted byte and checks each result transaction.
  always @(posedge clk) begin : watch_ports
    slot_check_t want;
    key_taken <= s_axis_tvalid && s_axis_tready && !rst;
    if (rst) begin
      model_hash = '0;
      model_slots = SLOTS_RESET;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (slot_checks.size() == 0) begin
          report_failure("result with nothing expected", 'x, 1'bx, m_axis_tdata, m_axis_tuser);
        end else begin
          want = slot_checks.pop_front();
          if (m_axis_tdata !== {1'b0, want.slot} || m_axis_tuser !== want.err) begin
            report_failure("slot index mismatch", {1'b0, want.slot}, want.err,
                           m_axis_tdata, m_axis_tuser);
          end
        end
      end
      if (cfg_wr_en) begin
        model_slots = cfg_wr_data;
        slot_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_taken++;
        model_hash = elf_fold(model_hash, s_axis_tdata);
        if (s_axis_tlast) begin
          if (model_slots == '0) begin
            want = '{slot: '0, err: 1'b1};
            error_keys++;
          end else begin
            want = '{slot: SLOTS_W'(32'(model_hash) % 32'(model_slots)), err: 1'b0};
          end
          slot_checks.push_back(want);
          model_hash = '0;
          keys_done++;
        end
      end
    end
  end

  initial begin : stimulus
    int len;
    int phase_bytes;
    slots_t value;

    // Directed keys at the reset slot count: every index is zero.
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hff, 1'b1);
    // Zero slot count gives the error flag, and the hash must still clear.
    queue_slots('0);
    queue_byte(8'h5a, 1'b1);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'hff, 1'b1);
    // Widest slot count: the index is the raw hash; long 0xff runs overflow and fold.
    queue_slots(SLOTS_MAX);
    for (int i = 0; i < 8; i++) begin
      queue_byte(8'hff, i == 7);
    end
    queue_byte(8'haa, 1'b0);
    queue_byte(8'h55, 1'b1);
    queue_settle();
    // Small odd slot count with mixed bit patterns.
    queue_slots(SLOTS_W'(7));
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7f, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'ha5, 1'b0);
    queue_byte(8'h5a, 1'b1);

    // Random phases, each under its own slot count.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       value = SLOTS_RESET;
        1:       value = '0;
        2:       value = SLOTS_MAX;
        3:       value = SLOTS_W'(2);
        4:       value = SLOTS_W'(32'h0fff_ffff);
        5:       value = SLOTS_W'($urandom_range(1, 16));
        default: value = ($urandom_range(0, 1) == 0) ? SLOTS_W'($urandom())
                                                     : SLOTS_W'($urandom_range(1, 1000));
      endcase
      queue_slots(value);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        queue_random_key(len);
        phase_bytes += len;
        if (phase_bytes >= PHASE_BYTES / 2 && phase_bytes - len < PHASE_BYTES / 2 && p % 3 == 0)
        begin
          queue_settle();
        end
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Wait for every byte to go out and every result to come back.
    while (pending_jobs.size() != 0 || s_axis_tvalid || slot_checks.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    fail_count += slot_checks.size();

    $display("Covered %0d key bytes in %0d keys (%0d with zero slots) over %0d slot-count writes.",
             bytes_taken, keys_done, error_keys, slot_writes);
    if (fail_count == 0) begin
      $display("elf_hash_slot_index_tb: clean");
    end else begin
      $display("Mismatches counted: %0d.", fail_count);
      $display("elf_hash_slot_index_tb: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("Run timed out with %0d results outstanding.", slot_checks.size());
    $display("elf_hash_slot_index_tb: errors");
    $finish;
  end

endmodule
